// ===== rtl/lpt_pkg.sv =====
// Shared types, codes and defaults for the live pointer tracker.
package lpt_pkg;

	localparam int TABLE_ENTRIES_DEF = 128;
	localparam int ADDRESS_BITS_DEF  = 32;
	localparam int FIELD_BITS        = 32;

	localparam logic [2:0] LEAD_BITS  = 3'd7;
	localparam logic [1:0] TRAIL_BITS = 2'd3;

	localparam logic [1:0] KIND_ALLOC   = 2'd0;
	localparam logic [1:0] KIND_FREE    = 2'd1;
	localparam logic [1:0] KIND_REALLOC = 2'd2;

	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_NULL    = 3'd1;
	localparam logic [2:0] STAT_FULL    = 3'd2;
	localparam logic [2:0] STAT_UNKNOWN = 3'd3;
	localparam logic [2:0] STAT_LEAD    = 3'd4;
	localparam logic [2:0] STAT_TRAIL   = 3'd5;
	localparam logic [2:0] STAT_BYPASS  = 3'd6;

	typedef struct packed {
		logic [1:0]            kind;
		logic [FIELD_BITS-1:0] address;
		logic [FIELD_BITS-1:0] new_address;
		logic [FIELD_BITS-1:0] leading_word;
		logic [FIELD_BITS-1:0] trailing_word;
	} in_item_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [FIELD_BITS-1:0] leading_canary;
		logic [FIELD_BITS-1:0] trailing_canary;
		logic                  error_flag;
	} out_item_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_res_t;

endpackage

// ===== rtl/lpt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module lpt_ram import lpt_pkg::*; #(
	parameter int WIDTH = ADDRESS_BITS_DEF,
	parameter int DEPTH = TABLE_ENTRIES_DEF
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/lpt_scan.sv =====
// Table scan engine: one shared equality compare, slot by slot to a hit.
module lpt_scan import lpt_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [ADDRESS_BITS-1:0]  key,
	output logic                     rd_en,
	output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] rd_addr,
	input  logic [ADDRESS_BITS-1:0]  rd_data,
	output scan_res_t                res,
	output logic [((TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1)-1:0] idx
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

	logic              issue_q;
	logic [IW-1:0]     cnt_q;
	logic [ADDRESS_BITS-1:0] key_q;
	logic              pend_s1;
	logic              last_s1;
	logic [IW-1:0]     idx_s1;
	logic              hit;

	assign hit       = pend_s1 && (rd_data == key_q);
	assign res.found = hit;
	assign res.done  = pend_s1 && (hit || last_s1);
	assign idx       = idx_s1;
	assign rd_en     = issue_q;
	assign rd_addr   = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else if (start) begin
			issue_q <= 1'b1;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else if (res.done) begin
			issue_q <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= issue_q;
			if (issue_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					issue_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q <= key;
		end
		if (issue_q) begin
			idx_s1  <= cnt_q;
			last_s1 <= (cnt_q == LAST);
		end
	end

endmodule

// ===== rtl/live_pointer_tracker_with_canary_check_core.sv =====
// Live pointer tracker top level: item sequencer, table memory and result register.
// After reset the block clears the table memory, one slot a cycle, with in_ready low.
// An item is then taken only while the block is idle, and in_ready comes back high at
// the edge that loads its result. A bypassed, null or undefined item goes straight to
// the finish state; an allocate or a free walks the table through one compare unit fed
// by the memory read port, one slot a cycle, and stops at the first free or matching
// slot; a reallocate runs a free walk for a non-null old address and, if that succeeds,
// an allocate walk for a non-null new address. The result waits in an output register,
// so the next item may enter while it is still unread; that item then holds in its
// finish state until the register is read.
module live_pointer_tracker_with_canary_check_core import lpt_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int IW        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int KEEP_BITS = (ADDRESS_BITS < FIELD_BITS) ? ADDRESS_BITS : FIELD_BITS;
	localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);
	localparam logic [ADDRESS_BITS-1:0] LEAD_MASK  = ADDRESS_BITS'(LEAD_BITS);
	localparam logic [ADDRESS_BITS-1:0] TRAIL_MASK = ADDRESS_BITS'(TRAIL_BITS);

	localparam logic [2:0] S_CLEAR      = 3'd0;
	localparam logic [2:0] S_IDLE       = 3'd1;
	localparam logic [2:0] S_FREE_SCAN  = 3'd2;
	localparam logic [2:0] S_ALLOC_SCAN = 3'd3;
	localparam logic [2:0] S_FIN        = 3'd4;

	logic [2:0]              state_q, state_d;
	logic [IW-1:0]           clr_q;
	logic                    err_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic [1:0]              kind_q;
	logic [ADDRESS_BITS-1:0] a_q, na_q, lead_q, trail_q, alloc_q;
	logic [2:0]              stat_q;
	logic                    trk_q;

	logic [ADDRESS_BITS-1:0] a_w, na_w, lead_w, trail_w;
	logic                    accept, lead_bad, trail_bad, stat_err, fin_load;

	logic                    set_stat, set_alloc, set_trk;
	logic [2:0]              stat_d;
	logic [ADDRESS_BITS-1:0] alloc_d;

	logic                    scan_start;
	logic [ADDRESS_BITS-1:0] scan_key;
	scan_res_t               scan_res;
	logic [IW-1:0]           scan_idx;
	logic                    rd_en;
	logic [IW-1:0]           rd_addr;
	logic [ADDRESS_BITS-1:0] rd_data;
	logic                    we;
	logic [IW-1:0]           waddr;
	logic [ADDRESS_BITS-1:0] wdata;

	assign a_w     = ADDRESS_BITS'(in_data.address[KEEP_BITS-1:0]);
	assign na_w    = ADDRESS_BITS'(in_data.new_address[KEEP_BITS-1:0]);
	assign lead_w  = ADDRESS_BITS'(in_data.leading_word[KEEP_BITS-1:0]);
	assign trail_w = ADDRESS_BITS'(in_data.trailing_word[KEEP_BITS-1:0]);

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign lead_bad  = (lead_q != (a_q | LEAD_MASK));
	assign trail_bad = (trail_q != (a_q | TRAIL_MASK));
	assign stat_err  = (stat_q == STAT_FULL) || (stat_q == STAT_UNKNOWN) ||
		(stat_q == STAT_LEAD) || (stat_q == STAT_TRAIL);
	assign fin_load  = (state_q == S_FIN) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		state_d    = state_q;
		scan_start = 1'b0;
		scan_key   = '0;
		we         = 1'b0;
		waddr      = clr_q;
		wdata      = '0;
		set_stat   = 1'b0;
		stat_d     = STAT_NULL;
		set_alloc  = 1'b0;
		alloc_d    = a_w;
		set_trk    = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				if (clr_q == LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					set_stat = 1'b1;
					state_d  = S_FIN;
					if (err_q) begin
						stat_d = STAT_BYPASS;
					end else begin
						unique case (in_data.kind)
							KIND_ALLOC: begin
								if (a_w != '0) begin
									scan_start = 1'b1;
									set_alloc  = 1'b1;
									state_d    = S_ALLOC_SCAN;
								end
							end
							KIND_FREE: begin
								if (a_w != '0) begin
									scan_start = 1'b1;
									scan_key   = a_w;
									state_d    = S_FREE_SCAN;
								end
							end
							KIND_REALLOC: begin
								if (a_w != '0) begin
									scan_start = 1'b1;
									scan_key   = a_w;
									state_d    = S_FREE_SCAN;
								end else if (na_w != '0) begin
									scan_start = 1'b1;
									set_alloc  = 1'b1;
									alloc_d    = na_w;
									state_d    = S_ALLOC_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
			end
			S_FREE_SCAN: begin
				if (scan_res.done) begin
					set_stat = 1'b1;
					state_d  = S_FIN;
					if (!scan_res.found) begin
						stat_d = STAT_UNKNOWN;
					end else begin
						we    = 1'b1;
						waddr = scan_idx;
						priority if (lead_bad) begin
							stat_d = STAT_LEAD;
						end else if (trail_bad) begin
							stat_d = STAT_TRAIL;
						end else if (kind_q != KIND_REALLOC) begin
							stat_d = STAT_OK;
						end else if (na_q != '0) begin
							scan_start = 1'b1;
							set_alloc  = 1'b1;
							alloc_d    = na_q;
							state_d    = S_ALLOC_SCAN;
						end else begin
							stat_d = STAT_NULL;
						end
					end
				end
			end
			S_ALLOC_SCAN: begin
				if (scan_res.done) begin
					set_stat = 1'b1;
					state_d  = S_FIN;
					if (scan_res.found) begin
						we      = 1'b1;
						waddr   = scan_idx;
						wdata   = alloc_q;
						stat_d  = STAT_OK;
						set_trk = 1'b1;
					end else begin
						stat_d = STAT_FULL;
					end
				end
			end
			S_FIN: begin
				if (fin_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (fin_load) begin
				out_valid_q <= 1'b1;
				err_q       <= err_q | stat_err;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= in_data.kind;
			a_q     <= a_w;
			na_q    <= na_w;
			lead_q  <= lead_w;
			trail_q <= trail_w;
			trk_q   <= 1'b0;
		end else if (set_trk) begin
			trk_q <= 1'b1;
		end
		if (set_stat) begin
			stat_q <= stat_d;
		end
		if (set_alloc) begin
			alloc_q <= alloc_d;
		end
		if (fin_load) begin
			out_q.status          <= stat_q;
			out_q.leading_canary  <= trk_q ? FIELD_BITS'(alloc_q | LEAD_MASK) : '0;
			out_q.trailing_canary <= trk_q ? FIELD_BITS'(alloc_q | TRAIL_MASK) : '0;
			out_q.error_flag      <= err_q | stat_err;
		end
	end

	lpt_scan #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.ADDRESS_BITS  (ADDRESS_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.key     (scan_key),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.res     (scan_res),
		.idx     (scan_idx)
	);

	lpt_ram #(
		.WIDTH (ADDRESS_BITS),
		.DEPTH (TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_res.done |-> (state_q == S_FREE_SCAN || state_q == S_ALLOC_SCAN))
		else $error("scan result outside a scan state");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |=> err_q)
		else $error("sticky error cleared");

	a_bypass_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status == STAT_BYPASS) |-> out_q.error_flag)
		else $error("bypassed transaction without error flag");

	a_canary_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.status != STAT_OK) |->
		(out_q.leading_canary == '0 && out_q.trailing_canary == '0))
		else $error("canary on failed transaction");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("transaction taken during table clear");

endmodule

// ===== dv/tb.sv =====
// Testbench for the live pointer tracker: directed rows, then random transactions and a closing error check.
module tb;
	import lpt_pkg::*;

	localparam logic [1:0] KIND_UNDEF = 2'd3;
	localparam int RANDOM_ITEMS = 1680;
	localparam logic [2:0] ERROR_CODES [4] = '{STAT_FULL, STAT_UNKNOWN, STAT_LEAD, STAT_TRAIL};

	typedef struct packed {
		in_item_t  stim;
		logic      typed;
		out_item_t want;
	} dir_row_t;

	localparam int DIR_ROWS = 21;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{'{KIND_ALLOC, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0}, 1'b1,
			'{STAT_OK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0}},
		'{'{KIND_ALLOC, 32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
			'{STAT_OK, 32'h0000_0007, 32'h0000_0003, 1'b0}},
		'{'{KIND_ALLOC, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
			'{STAT_NULL, 32'h0, 32'h0, 1'b0}},
		'{'{KIND_FREE, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0}, 1'b1,
			'{STAT_NULL, 32'h0, 32'h0, 1'b0}},
		'{'{KIND_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
			'{STAT_NULL, 32'h0, 32'h0, 1'b0}},
		'{'{KIND_UNDEF, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
			'{STAT_NULL, 32'h0, 32'h0, 1'b0}},
		'{'{KIND_FREE, 32'h0000_0001, 32'h0, 32'h0000_0007, 32'h0000_0003}, 1'b1,
			'{STAT_OK, 32'h0, 32'h0, 1'b0}},
		'{'{KIND_FREE, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
			'{STAT_OK, 32'h0, 32'h0, 1'b0}},
		'{'{KIND_ALLOC, 32'h8000_0000, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{'{KIND_REALLOC, 32'h8000_0000, 32'h1234_5678, 32'h8000_0007, 32'h8000_0003}, 1'b0, '0},
		'{'{KIND_REALLOC, 32'h0, 32'hA5A5_A5A0, 32'h0, 32'h0}, 1'b0, '0},
		'{'{KIND_REALLOC, 32'h1234_5678, 32'h0, 32'h1234_567F, 32'h1234_567B}, 1'b0, '0},
		'{'{KIND_REALLOC, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b1,
			'{STAT_NULL, 32'h0, 32'h0, 1'b0}},
		'{'{KIND_ALLOC, 32'h0000_0004, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{'{KIND_ALLOC, 32'h0000_0004, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
		'{'{KIND_FREE, 32'h0000_0004, 32'h0, 32'h0000_0007, 32'h0000_0007}, 1'b0, '0},
		'{'{KIND_FREE, 32'h0000_0004, 32'h0, 32'h0000_0007, 32'h0000_0007}, 1'b0, '0},
		'{'{KIND_ALLOC, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0}, 1'b0, '0},
		'{'{KIND_REALLOC, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, '0},
		'{'{KIND_FREE, 32'hA5A5_A5A0, 32'h0, 32'hA5A5_A5A7, 32'hA5A5_A5A3}, 1'b0, '0},
		'{'{KIND_FREE, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0}
	};

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	logic [FIELD_BITS-1:0] live_slots [TABLE_ENTRIES_DEF];
	logic                  sticky_err;
	out_item_t             due_results [$];
	out_item_t             head;
	logic [FIELD_BITS-1:0] live_addrs [$];
	logic                  fill_mode = 1'b1;
	int                    send_idle_pct = 28;
	int                    recv_idle_pct = 80;
	int                    mismatches = 0;

	live_pointer_tracker_with_canary_check_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [2:0] slot_take(input logic [FIELD_BITS-1:0] a);
		for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
			if (live_slots[i] == '0) begin
				live_slots[i] = a;
				return STAT_OK;
			end
		end
		return STAT_FULL;
	endfunction

	function automatic logic [2:0] slot_release(input logic [FIELD_BITS-1:0] a, lead, trail);
		int hit;
		hit = -1;
		for (int i = 0; i < TABLE_ENTRIES_DEF && hit < 0; i++)
			if (live_slots[i] == a)
				hit = i;
		if (hit < 0)
			return STAT_UNKNOWN;
		live_slots[hit] = '0;
		if (lead != (a | LEAD_BITS))
			return STAT_LEAD;
		if (trail != (a | TRAIL_BITS))
			return STAT_TRAIL;
		return STAT_OK;
	endfunction

	function automatic out_item_t canary_predict(input in_item_t it);
		out_item_t             r;
		logic [2:0]            freed;
		logic [FIELD_BITS-1:0] tracked;
		r = '0;
		r.status = STAT_NULL;
		tracked = '0;
		if (sticky_err) begin
			r.status = STAT_BYPASS;
		end else begin
			case (it.kind)
			KIND_ALLOC: if (it.address != '0) begin
				r.status = slot_take(it.address);
				if (r.status == STAT_OK)
					tracked = it.address;
			end
			KIND_FREE: if (it.address != '0) begin
				r.status = slot_release(it.address, it.leading_word, it.trailing_word);
			end
			KIND_REALLOC: begin
				freed = STAT_OK;
				if (it.address != '0)
					freed = slot_release(it.address, it.leading_word, it.trailing_word);
				if (freed != STAT_OK) begin
					r.status = freed;
				end else if (it.new_address != '0) begin
					r.status = slot_take(it.new_address);
					if (r.status == STAT_OK)
						tracked = it.new_address;
				end
			end
			default: r.status = STAT_NULL;
			endcase
		end
		if (r.status == STAT_FULL || r.status == STAT_UNKNOWN || r.status == STAT_LEAD ||
				r.status == STAT_TRAIL)
			sticky_err = 1'b1;
		r.leading_canary  = tracked == '0 ? '0 : tracked | LEAD_BITS;
		r.trailing_canary = tracked == '0 ? '0 : tracked | TRAIL_BITS;
		r.error_flag      = sticky_err;
		return r;
	endfunction

	function automatic logic [FIELD_BITS-1:0] rand_address();
		logic [FIELD_BITS-1:0] a;
		do begin
			case ($urandom_range(3))
			0: a = $urandom_range(15);
			1: a = $urandom & 32'hFFFF_FFF8;
			default: a = $urandom;
			endcase
		end while (a == '0);
		return a;
	endfunction

	function automatic in_item_t alloc_item();
		in_item_t it;
		it.kind = KIND_ALLOC;
		if (live_addrs.size() != 0 && $urandom_range(9) == 0)
			it.address = live_addrs[$urandom_range(live_addrs.size() - 1)];
		else
			it.address = rand_address();
		it.new_address   = $urandom;
		it.leading_word  = $urandom;
		it.trailing_word = $urandom;
		live_addrs.push_back(it.address);
		return it;
	endfunction

	function automatic logic [FIELD_BITS-1:0] take_live();
		int unsigned           idx;
		logic [FIELD_BITS-1:0] a;
		idx = $urandom_range(live_addrs.size() - 1);
		a = live_addrs[idx];
		live_addrs.delete(idx);
		return a;
	endfunction

	task automatic build_random(output in_item_t it);
		int unsigned pick;
		logic        room;
		pick = $urandom_range(99);
		room = live_addrs.size() < TABLE_ENTRIES_DEF;
		if (!room)
			fill_mode = 1'b0;
		if (live_addrs.size() == 0)
			fill_mode = 1'b1;
		it.kind          = KIND_UNDEF;
		it.address       = $urandom;
		it.new_address   = $urandom;
		it.leading_word  = $urandom;
		it.trailing_word = $urandom;
		if (pick >= 6) begin
			pick = $urandom_range(99);
			if (room && (live_addrs.size() == 0 || pick < (fill_mode ? 70 : 15))) begin
				it = alloc_item();
			end else begin
				it.kind          = pick < 85 ? KIND_FREE : KIND_REALLOC;
				it.address       = take_live();
				it.leading_word  = it.address | LEAD_BITS;
				it.trailing_word = it.address | TRAIL_BITS;
				if (it.kind == KIND_REALLOC) begin
					it.new_address = $urandom_range(9) == 0 ? '0 : rand_address();
					if (it.new_address != '0)
						live_addrs.push_back(it.new_address);
				end
			end
		end else if (pick >= 4) begin
			it.kind        = KIND_REALLOC;
			it.address     = '0;
			it.new_address = room ? rand_address() : '0;
			if (it.new_address != '0)
				live_addrs.push_back(it.new_address);
		end else if (pick >= 2) begin
			it.kind    = pick == 2 ? KIND_ALLOC : KIND_FREE;
			it.address = '0;
		end
	endtask

	task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
		out_item_t predicted;
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		predicted = canary_predict(it);
		due_results.push_back(typed ? want : predicted);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [FIELD_BITS-1:0] want, got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(negedge clk) out_ready <= $urandom_range(99) >= recv_idle_pct;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due_results.size() == 0) begin
				$display("%0t: result with none expected: %p", $time, out_data);
				mismatches++;
			end else begin
				head = due_results.pop_front();
				check_field("status", FIELD_BITS'(head.status),
					FIELD_BITS'(out_data.status));
				check_field("leading_canary", head.leading_canary, out_data.leading_canary);
				check_field("trailing_canary", head.trailing_canary, out_data.trailing_canary);
				check_field("error_flag", FIELD_BITS'(head.error_flag),
					FIELD_BITS'(out_data.error_flag));
			end
		end
	end

	initial begin
		#24_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		in_item_t              item;
		int                    hits [$];
		logic [2:0]            err_pick;
		logic                  by_realloc;
		logic [FIELD_BITS-1:0] flip;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		sticky_err = 1'b0;
		foreach (live_slots[i])
			live_slots[i] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = ph == 0 ? 28 : ph == 1 ? 80 : 0;
			recv_idle_pct = ph == 0 ? 80 : ph == 1 ? 28 : 0;
			if (ph == 0)
				foreach (DIRECTED[r])
					send_item(DIRECTED[r].stim, DIRECTED[r].typed, DIRECTED[r].want);
			repeat (RANDOM_ITEMS / 3) begin
				build_random(item);
				send_item(item, 1'b0, '0);
			end
			drain_results();
		end

		// end the clean run with one error, then confirm everything after it is bypassed
		err_pick   = ERROR_CODES[$urandom_range(3)];
		by_realloc = 1'($urandom_range(1));
		if (err_pick == STAT_FULL)
			while (live_addrs.size() < TABLE_ENTRIES_DEF)
				send_item(alloc_item(), 1'b0, '0);
		else if (err_pick != STAT_UNKNOWN && live_addrs.size() == 0)
			send_item(alloc_item(), 1'b0, '0);
		item.kind = by_realloc ? KIND_REALLOC : err_pick == STAT_FULL ? KIND_ALLOC : KIND_FREE;
		item.new_address   = rand_address();
		item.leading_word  = $urandom;
		item.trailing_word = $urandom;
		case (err_pick)
		STAT_FULL: item.address = by_realloc ? '0 : rand_address();
		STAT_UNKNOWN: begin
			do begin
				item.address = rand_address();
				hits = live_addrs.find_index(x) with (x == item.address);
			end while (hits.size() != 0);
		end
		default: begin
			item.address = take_live();
			flip = 32'h1 << $urandom_range(31);
			item.leading_word  = (item.address | LEAD_BITS) ^
				(err_pick == STAT_LEAD ? flip : 32'h0);
			item.trailing_word = (item.address | TRAIL_BITS) ^
				(err_pick == STAT_TRAIL ? flip : 32'h0);
		end
		endcase
		send_item(item, 1'b0, '0);
		repeat (20) begin
			item.kind          = 2'($urandom_range(3));
			item.address       = $urandom;
			item.new_address   = $urandom;
			item.leading_word  = $urandom;
			item.trailing_word = $urandom;
			send_item(item, 1'b0, '0);
		end

		drain_results();
		repeat (2 * TABLE_ENTRIES_DEF + 8) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/lpt_pkg.sv
rtl/lpt_ram.sv
rtl/lpt_scan.sv
rtl/live_pointer_tracker_with_canary_check_core.sv
dv/tb.sv
